### src/pvc_pkg.sv
// Shared types, codes and defaults for the progressive Vigenere cipher block.
// Used by the top level, pvc_front, pvc_back and pvc_chk; depends on nothing.
package pvc_pkg;

  localparam int DEF_KEY_DEPTH    = 16;
  localparam int DEF_SHIFT_DEPTH  = 16;
  localparam int DEF_ALPHABET_MAX = 64;

  localparam int SYMBOL_W    = 6;
  localparam int INDEX_W     = 4;
  localparam int SHIFT_W     = 8;
  localparam int CFG_DATA_W  = 7;
  localparam int REG_INDEX_W = 3;
  localparam int CMDQ_DEPTH  = 2;
  localparam int RESQ_DEPTH  = 2;

  localparam logic [1:0] ACT_SYMBOL      = 2'd0;
  localparam logic [1:0] ACT_KEY_WRITE   = 2'd1;
  localparam logic [1:0] ACT_SHIFT_WRITE = 2'd2;

  localparam logic [1:0] SHIFT_FIXED       = 2'd0;
  localparam logic [1:0] SHIFT_PROGRESSIVE = 2'd1;
  localparam logic [1:0] SHIFT_CUSTOM      = 2'd2;

  localparam logic [REG_INDEX_W-1:0] REG_ALPHABET_LENGTH = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_DECRYPT_MODE    = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_SHIFT_MODE      = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_SHIFT_BACKWARD  = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_SHIFT_STEP      = 3'd4;
  localparam logic [REG_INDEX_W-1:0] REG_KEY_LENGTH      = 3'd5;
  localparam logic [REG_INDEX_W-1:0] REG_CUSTOM_COUNT    = 3'd6;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_WRITE = 2'd1,
    STATUS_ERROR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_SYMBOL,
    CMD_KEY_WR,
    CMD_SHIFT_WR,
    CMD_BAD
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_KEY,
    ST_RUN,
    ST_STEP,
    ST_SHIFT,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic [1:0]                action;
    logic [SYMBOL_W-1:0]       symbol;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [SHIFT_W-1:0] shift_value;
    logic                      first;
  } in_item_t;

  typedef struct packed {
    logic [SYMBOL_W-1:0] out_symbol;
    status_t             status;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t kind;
    in_item_t  item;
  } cmd_t;

  typedef struct packed {
    logic [6:0]        alphabet_length;
    logic              decrypt_mode;
    logic [1:0]        shift_sel;
    logic              shift_backward;
    logic signed [6:0] shift_step;
    logic [4:0]        key_span;
    logic [4:0]        custom_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    alphabet_length: 7'd26,
    decrypt_mode:    1'b0,
    shift_sel:       SHIFT_FIXED,
    shift_backward:  1'b0,
    shift_step:      7'sd1,
    key_span:        5'd1,
    custom_count:    5'd0
  };

endpackage

### src/progressive_vigenere_cipher.sv
// Top level of the progressive Vigenere cipher: configuration registers,
// front end and back end. Depends on pvc_pkg, pvc_front and pvc_back.
//
// Requests enter through push/full, one per edge with push high and full low.
// Action 0 enciphers or deciphers one symbol, actions 1 and 2 load a key or a
// custom shift table entry. Each request gives exactly one result, read from
// the result side while empty is low and taken with pop.
// A two-entry request queue sits between front and back, and a two-entry
// result queue after the back end, so requests keep coming while results wait.
// Table writes and error results pass only through the IDLE and EMIT states.
// A symbol runs through one shared remainder unit of 9 steps per pass: key
// reduction plus shift reduction in fixed and custom modes, two more passes
// for the running sum in progressive mode. Items are worked one at a time.
// When the result side stalls, the back end holds its finished result and the
// request queue fills, then full rises.
// Reset (rst, synchronous) empties both queues, restores the configuration
// defaults and clears key position, symbol position and running sum. Table
// contents are not cleared and must be written before use.
module progressive_vigenere_cipher #(
  parameter int KEY_DEPTH    = pvc_pkg::DEF_KEY_DEPTH,
  parameter int SHIFT_DEPTH  = pvc_pkg::DEF_SHIFT_DEPTH,
  parameter int ALPHABET_MAX = pvc_pkg::DEF_ALPHABET_MAX
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  pvc_pkg::in_item_t                   request,
  output logic                                full,
  input  logic                                pop,
  output pvc_pkg::out_item_t                  result,
  output logic                                empty,
  input  logic                                cfg_we,
  input  logic [pvc_pkg::REG_INDEX_W-1:0]     cfg_index,
  input  logic [pvc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  pvc_pkg::cfg_t cfg;
  pvc_pkg::cmd_t cmd;
  logic          cmd_pop;
  logic          cmd_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= pvc_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pvc_pkg::REG_ALPHABET_LENGTH: cfg.alphabet_length <= cfg_data[6:0];
        pvc_pkg::REG_DECRYPT_MODE:    cfg.decrypt_mode    <= cfg_data[0];
        pvc_pkg::REG_SHIFT_MODE:      cfg.shift_sel       <= cfg_data[1:0];
        pvc_pkg::REG_SHIFT_BACKWARD:  cfg.shift_backward  <= cfg_data[0];
        pvc_pkg::REG_SHIFT_STEP:      cfg.shift_step      <= $signed(cfg_data[6:0]);
        pvc_pkg::REG_KEY_LENGTH:      cfg.key_span        <= cfg_data[4:0];
        pvc_pkg::REG_CUSTOM_COUNT:    cfg.custom_count    <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  pvc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .request   (request),
    .full      (full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  pvc_back #(
    .KEY_DEPTH    (KEY_DEPTH),
    .SHIFT_DEPTH  (SHIFT_DEPTH),
    .ALPHABET_MAX (ALPHABET_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .result    (result),
    .empty     (empty)
  );

endmodule

### src/pvc_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module pvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/pvc_fifo.sv
// Small register-based queue with push/full and pop/empty sides.
// No dependencies.
module pvc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

### src/pvc_remu.sv
// Shared remainder unit: wraps a signed value into 0 .. len-1, one quotient bit per cycle.
// No dependencies.
module pvc_remu #(
  parameter int ALPHABET_MAX = 64
) (
  input  logic                                                        clk,
  input  logic                                                        rst,
  input  logic                                                        start,
  input  logic signed [(((($clog2(ALPHABET_MAX + 1)) > 8) ?
                         $clog2(ALPHABET_MAX + 1) : 8) + 2)-1:0]      value,
  input  logic [$clog2(ALPHABET_MAX + 1)-1:0]                         len,
  output logic                                                        done,
  output logic [$clog2(ALPHABET_MAX + 1)-1:0]                         result
);

  localparam int LW   = $clog2(ALPHABET_MAX + 1);
  localparam int MAGW = ((LW > 8) ? LW : 8) + 1;
  localparam int SW   = MAGW + 1;
  localparam int CNTW = $clog2(MAGW + 1);

  logic              busy;
  logic              neg;
  logic [MAGW-1:0]   mag;
  logic [LW-1:0]     rem;
  logic [CNTW-1:0]   cnt;
  logic [LW:0]       rem_sh;
  logic [LW-1:0]     rem_step;
  logic signed [SW-1:0] value_abs;

  always_comb begin
    rem_sh    = {rem, mag[MAGW-1]};
    rem_step  = (rem_sh >= {1'b0, len}) ? LW'(rem_sh - {1'b0, len}) : LW'(rem_sh);
    value_abs = value[SW-1] ? -value : value;
    result    = (neg && (rem != '0)) ? len - rem : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNTW'(1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= value[SW-1];
      mag <= MAGW'(value_abs);
      rem <= '0;
      cnt <= CNTW'(MAGW);
    end else if (busy) begin
      rem <= rem_step;
      mag <= {mag[MAGW-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

### src/pvc_front.sv
// Front end: accepts requests, classifies them by action and queues them.
// Depends on pvc_pkg and pvc_fifo.
module pvc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pvc_pkg::in_item_t  request,
  output logic               full,
  input  logic               cmd_pop,
  output pvc_pkg::cmd_t      cmd,
  output logic               cmd_empty
);

  pvc_pkg::cmd_t                        cmd_in;
  logic [$bits(pvc_pkg::cmd_t)-1:0]     cmd_bits;

  always_comb begin
    cmd_in.item = request;
    unique case (request.action)
      pvc_pkg::ACT_SYMBOL:      cmd_in.kind = pvc_pkg::CMD_SYMBOL;
      pvc_pkg::ACT_KEY_WRITE:   cmd_in.kind = pvc_pkg::CMD_KEY_WR;
      pvc_pkg::ACT_SHIFT_WRITE: cmd_in.kind = pvc_pkg::CMD_SHIFT_WR;
      default:                  cmd_in.kind = pvc_pkg::CMD_BAD;
    endcase
  end

  pvc_fifo #(
    .WIDTH ($bits(pvc_pkg::cmd_t)),
    .DEPTH (pvc_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty)
  );

  assign cmd = pvc_pkg::cmd_t'(cmd_bits);

endmodule

### src/pvc_back.sv
// Back end: runs queued requests through key/shift tables and the remainder unit.
// Depends on pvc_pkg, pvc_ram, pvc_remu and pvc_fifo.
module pvc_back #(
  parameter int KEY_DEPTH    = pvc_pkg::DEF_KEY_DEPTH,
  parameter int SHIFT_DEPTH  = pvc_pkg::DEF_SHIFT_DEPTH,
  parameter int ALPHABET_MAX = pvc_pkg::DEF_ALPHABET_MAX
) (
  input  logic               clk,
  input  logic               rst,
  input  pvc_pkg::cfg_t      cfg,
  input  logic               cmd_empty,
  input  pvc_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  logic               pop,
  output pvc_pkg::out_item_t result,
  output logic               empty
);

  localparam int LW   = $clog2(ALPHABET_MAX + 1);
  localparam int MAGW = ((LW > 8) ? LW : 8) + 1;
  localparam int SW   = MAGW + 1;
  localparam int KAW  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int SAW  = (SHIFT_DEPTH > 1) ? $clog2(SHIFT_DEPTH) : 1;
  localparam int TW   = LW + 2;

  pvc_pkg::back_state_t state, state_next;
  pvc_pkg::in_item_t    cur, cur_next;
  pvc_pkg::out_item_t   res, res_next;
  logic [LW-1:0]        key_r, key_r_next;
  logic signed [pvc_pkg::SHIFT_W-1:0] shift_q, shift_q_next;
  logic [KAW-1:0]       kp, kp_next;
  logic [4:0]           sp, sp_next;
  logic [LW-1:0]        running, running_next;

  logic [LW-1:0]        len;
  logic                 key_idx_ok;
  logic                 shift_idx_ok;
  logic                 sym_bad;
  logic                 custom_ok;
  logic                 kp_wrap;
  logic                 key_we;
  logic                 shift_we;
  logic [KAW-1:0]       key_raddr;
  logic [SAW-1:0]       shift_raddr;
  logic [pvc_pkg::SYMBOL_W-1:0] key_rdata;
  logic [pvc_pkg::SHIFT_W-1:0]  shift_rdata;

  logic                 mod_start;
  logic signed [SW-1:0] mod_value;
  logic                 mod_done;
  logic [LW-1:0]        mod_result;

  logic signed [SW-1:0] step_ext;
  logic signed [SW-1:0] extra_base;
  logic signed [SW-1:0] extra_val;
  logic [TW-1:0]        tlen;
  logic [TW-1:0]        two_len;
  logic [TW-1:0]        total;
  logic [TW-1:0]        reduced;

  logic                 out_push;
  logic                 out_full;
  logic [$bits(pvc_pkg::out_item_t)-1:0] res_bits;

  always_comb begin
    if (cfg.alphabet_length < 7'd2) begin
      len = LW'(2);
    end else if (32'(cfg.alphabet_length) > 32'(ALPHABET_MAX)) begin
      len = LW'(ALPHABET_MAX);
    end else begin
      len = LW'(cfg.alphabet_length);
    end
  end

  assign key_idx_ok   = 32'(cmd.item.entry_index) < 32'(KEY_DEPTH);
  assign shift_idx_ok = 32'(cmd.item.entry_index) < 32'(SHIFT_DEPTH);
  assign sym_bad      = 32'(cmd.item.symbol) >= 32'(len);
  assign custom_ok    = (sp < cfg.custom_count) && (32'(sp) < 32'(SHIFT_DEPTH));
  assign kp_wrap      = (32'(kp) + 32'd1 >= 32'(cfg.key_span)) ||
                        (32'(kp) + 32'd1 >= 32'(KEY_DEPTH));
  assign key_raddr    = cmd.item.first ? '0 : kp;
  assign shift_raddr  = SAW'(cmd.item.first ? 5'd0 : sp);

  pvc_ram #(
    .WIDTH (pvc_pkg::SYMBOL_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (KAW'(cmd.item.entry_index)),
    .wdata (cmd.item.symbol),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  pvc_ram #(
    .WIDTH (pvc_pkg::SHIFT_W),
    .DEPTH (SHIFT_DEPTH)
  ) u_shift_ram (
    .clk   (clk),
    .we    (shift_we),
    .waddr (SAW'(cmd.item.entry_index)),
    .wdata (cmd.item.shift_value),
    .raddr (shift_raddr),
    .rdata (shift_rdata)
  );

  pvc_remu #(
    .ALPHABET_MAX (ALPHABET_MAX)
  ) u_remu (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .value  (mod_value),
    .len    (len),
    .done   (mod_done),
    .result (mod_result)
  );

  always_comb begin
    step_ext = SW'($signed(cfg.shift_step));
    case (cfg.shift_sel)
      pvc_pkg::SHIFT_FIXED:  extra_base = step_ext;
      pvc_pkg::SHIFT_CUSTOM: extra_base = custom_ok ? SW'(shift_q) : '0;
      default:               extra_base = '0;
    endcase
    extra_val = cfg.shift_backward ? -extra_base : extra_base;

    tlen    = TW'(len);
    two_len = tlen << 1;
    if (cfg.decrypt_mode) begin
      total = TW'(cur.symbol) + two_len - TW'(key_r) - TW'(mod_result);
    end else begin
      total = TW'(cur.symbol) + TW'(key_r) + TW'(mod_result);
    end
    if (total >= two_len) begin
      reduced = total - two_len;
    end else if (total >= tlen) begin
      reduced = total - tlen;
    end else begin
      reduced = total;
    end
  end

  always_comb begin
    state_next   = state;
    cur_next     = cur;
    res_next     = res;
    key_r_next   = key_r;
    shift_q_next = shift_q;
    kp_next      = kp;
    sp_next      = sp;
    running_next = running;
    cmd_pop      = 1'b0;
    out_push     = 1'b0;
    key_we       = 1'b0;
    shift_we     = 1'b0;
    mod_start    = 1'b0;
    mod_value    = '0;

    unique case (state)
      pvc_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop             = 1'b1;
          cur_next            = cmd.item;
          res_next.out_symbol = '0;
          res_next.status     = pvc_pkg::STATUS_ERROR;
          state_next          = pvc_pkg::ST_EMIT;
          unique case (cmd.kind)
            pvc_pkg::CMD_KEY_WR: begin
              key_we          = key_idx_ok;
              res_next.status = pvc_pkg::STATUS_WRITE;
            end
            pvc_pkg::CMD_SHIFT_WR: begin
              shift_we        = shift_idx_ok;
              res_next.status = pvc_pkg::STATUS_WRITE;
            end
            pvc_pkg::CMD_SYMBOL: begin
              if (cmd.item.first) begin
                kp_next      = '0;
                sp_next      = '0;
                running_next = '0;
              end
              if (!sym_bad) begin
                state_next = pvc_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      pvc_pkg::ST_READ: begin
        shift_q_next = $signed(shift_rdata);
        mod_start    = 1'b1;
        mod_value    = SW'(key_rdata);
        state_next   = pvc_pkg::ST_KEY;
      end
      pvc_pkg::ST_KEY: begin
        if (mod_done) begin
          key_r_next = mod_result;
          mod_start  = 1'b1;
          if (cfg.shift_sel == pvc_pkg::SHIFT_PROGRESSIVE) begin
            mod_value  = SW'(running);
            state_next = pvc_pkg::ST_RUN;
          end else begin
            mod_value  = extra_val;
            state_next = pvc_pkg::ST_SHIFT;
          end
        end
      end
      pvc_pkg::ST_RUN: begin
        if (mod_done) begin
          mod_start  = 1'b1;
          mod_value  = SW'(mod_result) + step_ext;
          state_next = pvc_pkg::ST_STEP;
        end
      end
      pvc_pkg::ST_STEP: begin
        if (mod_done) begin
          running_next = mod_result;
          mod_start    = 1'b1;
          mod_value    = cfg.shift_backward ? -SW'(mod_result) : SW'(mod_result);
          state_next   = pvc_pkg::ST_SHIFT;
        end
      end
      pvc_pkg::ST_SHIFT: begin
        if (mod_done) begin
          res_next.out_symbol = pvc_pkg::SYMBOL_W'(reduced);
          res_next.status     = pvc_pkg::STATUS_DONE;
          kp_next             = kp_wrap ? '0 : kp + 1'b1;
          sp_next             = (&sp) ? sp : sp + 5'd1;
          state_next          = pvc_pkg::ST_EMIT;
        end
      end
      pvc_pkg::ST_EMIT: begin
        if (!out_full) begin
          out_push   = 1'b1;
          state_next = pvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pvc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pvc_pkg::ST_IDLE;
      kp      <= '0;
      sp      <= '0;
      running <= '0;
    end else begin
      state   <= state_next;
      kp      <= kp_next;
      sp      <= sp_next;
      running <= running_next;
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    res     <= res_next;
    key_r   <= key_r_next;
    shift_q <= shift_q_next;
  end

  pvc_fifo #(
    .WIDTH ($bits(pvc_pkg::out_item_t)),
    .DEPTH (pvc_pkg::RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (res),
    .full  (out_full),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty)
  );

  assign result = pvc_pkg::out_item_t'(res_bits);

endmodule

### src/pvc_chk.sv
// Port-level checker for the progressive Vigenere cipher, bound to its top level.
// Depends on pvc_pkg and progressive_vigenere_cipher.
module pvc_chk (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               pop,
  input pvc_pkg::out_item_t result,
  input logic               empty
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty ##1 empty)
    else $error("result offered too soon after reset");

  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("request side full after reset");

  a_side_result_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.status != pvc_pkg::STATUS_DONE)) |-> (result.out_symbol == '0))
    else $error("write or error result carries a nonzero symbol");

  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before pop");

endmodule

bind progressive_vigenere_cipher pvc_chk u_pvc_chk (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .pop    (pop),
  .result (result),
  .empty  (empty)
);
